@@ design/esc_pkg.sv @@
// Package for the C string literal escaper: transaction structs, queue job format,
// phase enum and the per-byte escape renderer. No dependencies.
package esc_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_F   = 8'h66;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_F   = 8'h46;
   localparam logic [7:0] CH_LC_X   = 8'h78;
   localparam logic [7:0] CH_NUL    = 8'h00;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_string;
      logic       empty_string;
   } esc_req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last_in_run;
   } esc_rsp_type;

   // One rendered byte: 0..4 characters
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [2:0]      len;
   } esc_seg_type;

   // Work for one input transaction: segment A, segment B, then q_cnt quotes
   typedef struct packed {
      esc_seg_type seg_a;
      esc_seg_type seg_b;
      logic [1:0]  q_cnt;
   } esc_job_type;

   typedef enum logic [1:0] {
      PH_A,
      PH_B,
      PH_Q
   } esc_phase_type;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = CH_ZERO + {4'd0, d};
      end else begin
         r = CH_LC_A + {4'd0, d} - 8'd10;
      end
      return r;
   endfunction

   function automatic esc_seg_type render(input logic [7:0] v, input logic [7:0] nx);
      esc_seg_type s;
      logic [7:0]  letter;
      logic        need;
      logic        nx_oct;
      logic        nx_hex;
      need   = (v == CH_BSLASH) || (v == CH_QUOTE) || (v == CH_DEL) ||
               (v < CH_SPACE) || v[7];
      nx_oct = (nx >= CH_ZERO) && (nx <= CH_SEVEN);
      nx_hex = ((nx >= CH_ZERO) && (nx <= CH_NINE)) ||
               ((nx >= CH_LC_A) && (nx <= CH_LC_F)) ||
               ((nx >= CH_UC_A) && (nx <= CH_UC_F));
      case (v)
         8'h09:     letter = 8'h74; // t
         8'h0A:     letter = 8'h6E; // n
         8'h0B:     letter = 8'h76; // v
         8'h0C:     letter = 8'h66; // f
         8'h0D:     letter = 8'h72; // r
         CH_BSLASH: letter = CH_BSLASH;
         CH_QUOTE:  letter = CH_QUOTE;
         default:   letter = CH_NUL;
      endcase
      s.chars = '0;
      if (!need) begin
         s.chars[0] = v;
         s.len      = 3'd1;
      end else if (letter != CH_NUL) begin
         s.chars[0] = CH_BSLASH;
         s.chars[1] = letter;
         s.len      = 3'd2;
      end else if ((v < 8'd8) && !nx_oct) begin
         s.chars[0] = CH_BSLASH;
         s.chars[1] = CH_ZERO + {5'd0, v[2:0]};
         s.len      = 3'd2;
      end else if ((v >= 8'd8) && !nx_hex) begin
         s.chars[0] = CH_BSLASH;
         s.chars[1] = CH_LC_X;
         s.chars[2] = hex_char(v[7:4]);
         s.chars[3] = hex_char(v[3:0]);
         s.len      = 3'd4;
      end else begin
         s.chars[0] = CH_BSLASH;
         s.chars[1] = CH_ZERO + {6'd0, v[7:6]};
         s.chars[2] = CH_ZERO + {5'd0, v[5:3]};
         s.chars[3] = CH_ZERO + {5'd0, v[2:0]};
         s.len      = 3'd4;
      end
      return s;
   endfunction

endpackage

@@ design/esc_front.sv @@
// Front end: keeps the held byte and turns each input transaction into a job.
// Depends on esc_pkg.
module esc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  esc_pkg::esc_req_type req_data,
   input  logic                 q_full,
   output logic                 q_push,
   output esc_pkg::esc_job_type q_job
);

   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic       accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   always_comb begin
      q_job         = '0;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      if (req_data.empty_string) begin
         if (held_valid_ff) begin
            q_job.seg_a = esc_pkg::render(held_byte_ff, esc_pkg::CH_NUL);
            q_job.q_cnt = 2'd3;
         end else begin
            q_job.q_cnt = 2'd2;
         end
      end else begin
         if (held_valid_ff) begin
            q_job.seg_a = esc_pkg::render(held_byte_ff, req_data.char_in);
         end else begin
            q_job.seg_a.chars[0] = esc_pkg::CH_QUOTE;
            q_job.seg_a.len      = 3'd1;
         end
         if (req_data.end_of_string) begin
            q_job.seg_b = esc_pkg::render(req_data.char_in, esc_pkg::CH_NUL);
            q_job.q_cnt = 2'd1;
         end
      end
      if (accept) begin
         if (req_data.empty_string || req_data.end_of_string) begin
            held_byte_in  = '0;
            held_valid_in = 1'b0;
         end else begin
            held_byte_in  = req_data.char_in;
            held_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule

@@ design/esc_queue.sv @@
// Small register FIFO of jobs between front and back end.
// Depends on esc_pkg.
module esc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  esc_pkg::esc_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output esc_pkg::esc_job_type head_job
);

   esc_pkg::esc_job_type entry_ff [esc_pkg::QUEUE_DEPTH];
   logic [esc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [esc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [esc_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == esc_pkg::QCNT_W'(esc_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];

   function automatic logic [esc_pkg::QPTR_W-1:0] ptr_inc(
      input logic [esc_pkg::QPTR_W-1:0] p);
      logic [esc_pkg::QPTR_W-1:0] r;
      if (p == esc_pkg::QPTR_W'(esc_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ design/esc_back.sv @@
// Back end: walks the head job one character per cycle, when not stalled, into the output register.
// Depends on esc_pkg.
module esc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  esc_pkg::esc_job_type q_job,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output esc_pkg::esc_rsp_type rsp_data
);

   esc_pkg::esc_phase_type phase_ff, phase_in, cur_ph, start_ph, next_ph;
   logic [1:0] idx_ff, idx_in, cur_idx;
   logic       started_ff, started_in;
   logic       rsp_valid_ff, rsp_valid_in;
   esc_pkg::esc_rsp_type rsp_data_ff, rsp_data_in;
   logic [2:0] cur_len;
   logic [7:0] cur_char;
   logic       more_in_seg, has_next, last, emit;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign emit      = q_not_empty && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = emit && last;

   always_comb begin
      // first non-empty segment of a fresh job
      if (q_job.seg_a.len != '0) begin
         start_ph = esc_pkg::PH_A;
      end else if (q_job.seg_b.len != '0) begin
         start_ph = esc_pkg::PH_B;
      end else begin
         start_ph = esc_pkg::PH_Q;
      end
      cur_ph  = started_ff ? phase_ff : start_ph;
      cur_idx = started_ff ? idx_ff : 2'd0;

      unique case (cur_ph)
         esc_pkg::PH_A: begin
            cur_len  = q_job.seg_a.len;
            cur_char = q_job.seg_a.chars[cur_idx];
            has_next = (q_job.seg_b.len != '0) || (q_job.q_cnt != '0);
            next_ph  = (q_job.seg_b.len != '0) ? esc_pkg::PH_B : esc_pkg::PH_Q;
         end
         esc_pkg::PH_B: begin
            cur_len  = q_job.seg_b.len;
            cur_char = q_job.seg_b.chars[cur_idx];
            has_next = (q_job.q_cnt != '0);
            next_ph  = esc_pkg::PH_Q;
         end
         esc_pkg::PH_Q: begin
            cur_len  = {1'b0, q_job.q_cnt};
            cur_char = esc_pkg::CH_QUOTE;
            has_next = 1'b0;
            next_ph  = esc_pkg::PH_Q;
         end
         default: begin
            cur_len  = '0;
            cur_char = esc_pkg::CH_QUOTE;
            has_next = 1'b0;
            next_ph  = esc_pkg::PH_Q;
         end
      endcase

      more_in_seg = ({1'b0, cur_idx} + 3'd1) < cur_len;
      last        = !more_in_seg && !has_next;

      phase_in     = phase_ff;
      idx_in       = idx_ff;
      started_in   = started_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.char_out = cur_char;
         rsp_data_in.last_in_run = last;
         if (last) begin
            started_in = 1'b0;
         end else if (more_in_seg) begin
            started_in = 1'b1;
            phase_in   = cur_ph;
            idx_in     = cur_idx + 2'd1;
         end else begin
            started_in = 1'b1;
            phase_in   = next_ph;
            idx_in     = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= esc_pkg::PH_A;
         idx_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ design/c_string_literal_escaper.sv @@
// Top level of the C string literal escaper: front end, job queue, back end.
// Depends on esc_pkg, esc_front, esc_queue, esc_back.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | esc_req_type (char_in, flags)
//   rsp_    | out       | rsp_valid/rsp_stall  | esc_rsp_type (char_out, last_in_run)
//
// The back end emits one character per cycle while a job is queued and rsp_stall allows it;
// a transaction yields 1 to 9 output characters: a plain byte renders to one, an escaped byte up to 4.
// The front end renders a transaction in the cycle it is accepted; a two-entry job
// queue lets it take new transactions while the back end drains.
// req_stall is high only while the queue is full. Synchronous reset clears the
// held byte, the queue and the output valid flag.
module c_string_literal_escaper (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  esc_pkg::esc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output esc_pkg::esc_rsp_type rsp_data
);

   logic                 q_full, q_push, q_pop, q_not_empty;
   esc_pkg::esc_job_type push_job, head_job;

   esc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   esc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   esc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_job       (head_job),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
